/* rtl/sha256_pkg.sv */
// Shared types, constants and round-constant table of the SHA-256 message hasher.
package sha256_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned FillW    = 4;
    localparam int unsigned RoundW   = 6;
    localparam int unsigned IdxW     = 3;
    localparam int unsigned CountW   = 3;
    localparam logic [WordW-1:0] PadWord = 32'h8000_0000;

    typedef logic [WordW-1:0] t_word;

    // Source of the word pushed into the block window.
    typedef enum logic [2:0] {
        WSEL_INPUT,
        WSEL_PAD80,
        WSEL_ZERO,
        WSEL_LEN_HI,
        WSEL_LEN_LO
    } t_word_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              push;
        t_word_sel         sel;
        logic              load_work;
        logic              round;
        logic [RoundW-1:0] round_idx;
        logic              finalize;
        logic              reinit;
        logic [IdxW-1:0]   out_idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FillW-1:0] fill;
        logic             in_last;
        logic             in_cnt4;
    } t_status;

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constant K for round r.
    function automatic t_word round_k(input logic [RoundW-1:0] r);
        t_word k;
        unique case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

/* rtl/sha256_if.sv */
// Valid/ready channel interfaces for message words and digest words.
interface sha256_in_if;
    logic                              valid;
    logic                              ready;
    logic [sha256_pkg::WordW-1:0]      data_word;
    logic [sha256_pkg::CountW-1:0]     byte_count;
    logic                              last_word;

    modport source (output valid, data_word, byte_count, last_word, input ready);
    modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sha256_out_if;
    logic                              valid;
    logic                              ready;
    logic [sha256_pkg::WordW-1:0]      digest_word;
    logic [sha256_pkg::IdxW-1:0]       word_index;
    logic                              digest_done;

    modport source (output valid, digest_word, word_index, digest_done, input ready);
    modport sink   (input valid, digest_word, word_index, digest_done, output ready);
endinterface

/* rtl/sha256_datapath.sv */
// Datapath: block window, message schedule, round unit, chaining value and length.
module sha256_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sha256_pkg::t_cmd              i_cmd,
    input  logic [sha256_pkg::WordW-1:0]  i_data_word,
    input  logic [sha256_pkg::CountW-1:0] i_byte_count,
    input  logic                          i_last_word,
    output sha256_pkg::t_status           o_status,
    output logic [sha256_pkg::WordW-1:0]  o_digest_word
);
    import sha256_pkg::*;

    t_word            r_win [16];
    t_word            r_work [8];
    t_word            r_chain [8];
    logic [FillW-1:0] r_fill;
    logic [63:0]      r_bytes;

    t_word       w_in_word;
    t_word       w_push_word;
    t_word       w_sched;
    t_word       w_t1;
    t_word       w_t2;
    t_word       w_s0;
    t_word       w_s1;
    logic [63:0] w_bits;
    logic [63:0] w_add_bytes;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    // Word formed from the input item, with padding on a short last word.
    always_comb begin
        w_in_word = i_data_word;
        if (i_last_word && !i_byte_count[2]) begin
            case (i_byte_count[1:0])
                2'd0:    w_in_word = PadWord;
                2'd1:    w_in_word = {i_data_word[31:24], 24'h80_0000};
                2'd2:    w_in_word = {i_data_word[31:16], 16'h8000};
                default: w_in_word = {i_data_word[31:8], 8'h80};
            endcase
        end
        if (i_last_word && !i_byte_count[2]) begin
            w_add_bytes = {61'd0, i_byte_count};
        end else begin
            w_add_bytes = 64'd4;
        end
    end

    assign w_bits = {r_bytes[60:0], 3'b000};

    // Word pushed into the window.
    always_comb begin
        case (i_cmd.sel)
            WSEL_INPUT:  w_push_word = w_in_word;
            WSEL_PAD80:  w_push_word = PadWord;
            WSEL_LEN_HI: w_push_word = w_bits[63:32];
            WSEL_LEN_LO: w_push_word = w_bits[31:0];
            default:     w_push_word = '0;
        endcase
    end

    // Schedule expansion over the sliding window and one round.
    always_comb begin
        w_s0 = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        w_s1 = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
        w_sched = r_win[0] + w_s0 + r_win[9] + w_s1;
        w_t1 = r_work[7]
             + (rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25))
             + ((r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]))
             + round_k(i_cmd.round_idx) + r_win[0];
        w_t2 = (rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22))
             + ((r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                ^ (r_work[1] & r_work[2]));
    end

    // Window and working variables hold no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
            r_win[15] <= w_push_word;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
            r_win[15] <= w_sched;
        end
        if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++) r_work[i] <= r_chain[i];
        end else if (i_cmd.round) begin
            r_work[0] <= w_t1 + w_t2;
            r_work[1] <= r_work[0];
            r_work[2] <= r_work[1];
            r_work[3] <= r_work[2];
            r_work[4] <= r_work[3] + w_t1;
            r_work[5] <= r_work[4];
            r_work[6] <= r_work[5];
            r_work[7] <= r_work[6];
        end
    end

    // Chaining value, fill count and byte length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= IV[i];
            r_fill  <= '0;
            r_bytes <= '0;
        end else begin
            if (i_cmd.finalize) begin
                for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_work[i];
            end
            if (i_cmd.push) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.push && i_cmd.sel == WSEL_INPUT) begin
                r_bytes <= r_bytes + w_add_bytes;
            end
        end
    end

    assign o_status.fill    = r_fill;
    assign o_status.in_last = i_last_word;
    assign o_status.in_cnt4 = i_byte_count[2];
    assign o_digest_word    = r_chain[i_cmd.out_idx];

endmodule

/* rtl/sha256_ctrl.sv */
// Controller: sequences word pushes, padding, the 64 rounds and digest output.
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  sha256_pkg::t_status i_status,
    output sha256_pkg::t_cmd    o_cmd
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_FIN, S_OUT} t_state;
    typedef enum logic [2:0] {PH_NONE, PH_80, PH_ZERO, PH_HI, PH_LO, PH_DONE} t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [RoundW-1:0] r_round, n_round;
    logic [IdxW-1:0]   r_idx, n_idx;
    logic              w_full;
    logic              w_in_hs;
    logic              w_out_hs;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign w_in_hs     = i_in_valid && o_in_ready;
    assign w_out_hs    = o_out_valid && i_out_ready;
    assign w_full      = (i_status.fill == {FillW{1'b1}});

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_round = r_round;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.sel       = WSEL_INPUT;
        o_cmd.round_idx = r_round;
        o_cmd.out_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_hs) begin
                    o_cmd.push = 1'b1;
                    if (!i_status.in_last)     n_phase = PH_NONE;
                    else if (i_status.in_cnt4) n_phase = PH_80;
                    else                       n_phase = PH_ZERO;
                    if (w_full)                 n_state = S_COMP;
                    else if (i_status.in_last)  n_state = S_PAD;
                end
            end
            S_PAD: begin
                o_cmd.push = 1'b1;
                case (r_phase)
                    PH_80: begin
                        o_cmd.sel = WSEL_PAD80;
                        n_phase   = PH_ZERO;
                    end
                    PH_ZERO: begin
                        o_cmd.sel = WSEL_ZERO;
                        if (i_status.fill == 4'd14) begin
                            o_cmd.push = 1'b0;
                            n_phase    = PH_HI;
                        end
                    end
                    PH_HI: begin
                        o_cmd.sel = WSEL_LEN_HI;
                        n_phase   = PH_LO;
                    end
                    default: begin
                        o_cmd.sel = WSEL_LEN_LO;
                        n_phase   = PH_DONE;
                    end
                endcase
                if (o_cmd.push && w_full) n_state = S_COMP;
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 1'b1;
                if (r_round == {RoundW{1'b1}}) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finalize = 1'b1;
                if (r_phase == PH_DONE)      n_state = S_OUT;
                else if (r_phase == PH_NONE) n_state = S_IDLE;
                else                         n_state = S_PAD;
            end
            S_OUT: begin
                if (w_out_hs) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == {IdxW{1'b1}}) begin
                        o_cmd.reinit = 1'b1;
                        n_phase      = PH_NONE;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Working variables load as the sixteenth word of a block goes in.
        o_cmd.load_work = o_cmd.push && w_full;
    end

    // State and registered control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_NONE;
            r_round <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_round <= n_round;
            r_idx   <= n_idx;
        end
    end

`ifndef SYNTHESIS
    // The last round hands over to the chaining update.
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && r_round == {RoundW{1'b1}}) |=> (r_state == S_FIN))
        else $error("round sequence did not end in chaining update");
    // No item is taken while a digest is being delivered.
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready during digest output");
    // The eighth digest word returns the block to idle.
    a_out_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_hs && r_idx == {IdxW{1'b1}}) |=> (r_state == S_IDLE && r_idx == '0))
        else $error("digest output did not finish cleanly");
    // A full window always starts the rounds.
    a_full_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.push && w_full) |=> (r_state == S_COMP && r_round == '0))
        else $error("full block did not start compression");
`endif

endmodule

/* rtl/sha256_message_hasher.sv */
// Top level of the SHA-256 message hasher: controller plus datapath.
// A message word is taken while the hasher is idle; the word that completes a block starts
// the 64 rounds of the single iterated round unit, followed by the chaining add.
// After the last word come the padding and length words, a step where the zeros reach the
// length slot, rounds for any further block, then eight digest items at one per ready cycle.
// Reset is synchronous, active low, and restores the initial hash value.
module sha256_message_hasher (
    input  logic i_clk,
    input  logic i_rst_n,
    sha256_in_if.sink    i_in,
    sha256_out_if.source o_out
);
    import sha256_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sha256_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_word   (i_in.data_word),
        .i_byte_count  (i_in.byte_count),
        .i_last_word   (i_in.last_word),
        .o_status      (w_status),
        .o_digest_word (o_out.digest_word)
    );

    assign o_out.word_index  = w_cmd.out_idx;
    assign o_out.digest_done = (w_cmd.out_idx == {IdxW{1'b1}});

endmodule

/* sim/testbench.sv */
// Self-checking SHA-256 hasher testbench: directed and random messages against a digest predictor.
`timescale 1ns / 1ps

module testbench;
    import sha256_pkg::*;

    localparam int unsigned IdleLimit = 20000;
    localparam int unsigned DrainCycles = 300;

    typedef struct packed {
        t_word           data;
        logic [CountW-1:0] count;
        logic            last;
    } t_msg_word;

    typedef struct packed {
        t_word         word;
        logic [IdxW-1:0] idx;
        logic          done;
    } t_digest_item;

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha256_in_if  in_ch();
    sha256_out_if out_ch();

    sha256_message_hasher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: chaining value, block window and byte length.
    t_word       hash_state [8];
    t_word       window [16];
    int unsigned window_fill;
    logic [63:0] byte_length;

    t_msg_word    pending_words [$];
    t_digest_item digest_expected [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_sender = 1'b0;
    bit  stim_done = 1'b0;
    bit  in_accepted = 1'b0;
    int  error_count = 0;
    int  words_sent = 0;
    int  digests_seen = 0;
    int  idle_cycles = 0;

    function automatic t_word rotr(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Runs the 64 rounds on the window and folds the result into the chaining value.
    task automatic compress_window();
        t_word w [64];
        t_word v [8];
        t_word t1, t2, e, a;
        for (int r = 0; r < 16; r++) w[r] = window[r];
        for (int r = 16; r < 64; r++) begin
            w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                 + w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
        end
        for (int r = 0; r < 8; r++) v[r] = hash_state[r];
        for (int r = 0; r < 64; r++) begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
               + RoundK[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++) hash_state[r] = hash_state[r] + v[r];
    endtask

    task automatic append_word(t_word w);
        window[window_fill] = w;
        window_fill++;
        if (window_fill == 16) begin
            compress_window();
            window_fill = 0;
        end
    endtask

    // Absorbs one accepted message word; the last word pads and yields the digest.
    task automatic absorb_word(t_msg_word m);
        int unsigned cnt;
        t_word mask;
        logic [63:0] bit_length;
        t_digest_item d;
        if (!m.last) begin
            append_word(m.data);
            byte_length += 4;
            return;
        end
        cnt = (m.count > 4) ? 4 : m.count;
        byte_length += cnt;
        if (cnt == 4) begin
            append_word(m.data);
            append_word(PadWord);
        end else begin
            mask = (cnt == 0) ? '0 : (32'hffff_ffff << (32 - 8 * cnt));
            append_word((m.data & mask) | (32'h80 << (24 - 8 * cnt)));
        end
        if (window_fill > 14) begin
            while (window_fill != 0) append_word('0);
        end
        while (window_fill < 14) append_word('0);
        bit_length = byte_length << 3;
        append_word(bit_length[63:32]);
        append_word(bit_length[31:0]);
        for (int k = 0; k < 8; k++) begin
            d.word = hash_state[k];
            d.idx = k[IdxW-1:0];
            d.done = (k == 7);
            digest_expected.push_back(d);
        end
        for (int k = 0; k < 8; k++) hash_state[k] = IV[k];
        window_fill = 0;
        byte_length = '0;
    endtask

    function automatic t_msg_word body_word();
        t_msg_word m;
        m.data = $urandom;
        m.count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
        m.last = 1'b0;
        return m;
    endfunction

    task automatic queue_message(int unsigned n_words, logic [CountW-1:0] last_cnt);
        t_msg_word m;
        for (int unsigned i = 0; i < n_words; i++) pending_words.push_back(body_word());
        m.data = $urandom;
        m.count = last_cnt;
        m.last = 1'b1;
        pending_words.push_back(m);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (digest_expected.size() != 0) @(posedge i_clk);
    endtask

    // Driver: presents queued words at the falling edge, idling at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_accepted) begin
            if (pending_words.size() != 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                in_ch.valid      <= 1'b1;
                in_ch.data_word  <= pending_words[0].data;
                in_ch.byte_count <= pending_words[0].count;
                in_ch.last_word  <= pending_words[0].last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: predicts on accepted words and checks every digest item.
    always @(posedge i_clk) begin
        t_msg_word m;
        t_digest_item exp_item;
        bit in_hs;
        bit out_hs;
        in_hs = in_ch.valid && in_ch.ready;
        out_hs = out_ch.valid && out_ch.ready;
        in_accepted <= in_hs;
        if (i_rst_n) begin
            if (in_hs || out_hs) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (in_hs) begin
                m = pending_words.pop_front();
                absorb_word(m);
                words_sent <= words_sent + 1;
            end
            if (out_hs) begin
                digests_seen <= digests_seen + 1;
                if (digest_expected.size() == 0) begin
                    $display("%0t: unexpected digest item: word %h idx %0d done %b", $time,
                             out_ch.digest_word, out_ch.word_index, out_ch.digest_done);
                    error_count <= error_count + 1;
                end else begin
                    exp_item = digest_expected.pop_front();
                    if (out_ch.digest_word !== exp_item.word ||
                        out_ch.word_index !== exp_item.idx ||
                        out_ch.digest_done !== exp_item.done) begin
                        $display("%0t: digest mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                                 $time, exp_item.word, exp_item.idx, exp_item.done,
                                 out_ch.digest_word, out_ch.word_index, out_ch.digest_done);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge i_clk) begin
        if (idle_cycles >= IdleLimit) begin
            $display("%0t: timeout with %0d digest items outstanding", $time,
                     digest_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_msg_word m;
        in_ch.valid = 1'b0;
        in_ch.data_word = '0;
        in_ch.byte_count = '0;
        in_ch.last_word = 1'b0;
        out_ch.ready = 1'b0;
        for (int k = 0; k < 8; k++) hash_state[k] = IV[k];
        window_fill = 0;
        byte_length = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty message, partial last words, extremes, one- and two-block pads.
        queue_message(0, 3'd0);
        m = '{data: 32'hffff_ffff, count: 3'd1, last: 1'b1};
        pending_words.push_back(m);
        m = '{data: 32'h0000_0000, count: 3'd2, last: 1'b1};
        pending_words.push_back(m);
        m = '{data: 32'hffff_ffff, count: 3'd3, last: 1'b1};
        pending_words.push_back(m);
        m = '{data: 32'h6162_6300, count: 3'd3, last: 1'b1};
        pending_words.push_back(m);
        m = '{data: 32'h8000_0001, count: 3'd7, last: 1'b1};
        pending_words.push_back(m);
        m = '{data: 32'hffff_ffff, count: 3'd1, last: 1'b0};
        pending_words.push_back(m);
        m = '{data: 32'hdead_beef, count: 3'd4, last: 1'b1};
        pending_words.push_back(m);
        queue_message(13, 3'd4);
        wait_drained();

        // Random messages across the idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 63 : 14) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 63 : 14) : 0;
            while (words_sent + pending_words.size() < 5 + (phase + 1) * 88) begin
                case ($urandom_range(0, 5))
                    0: queue_message($urandom_range(0, 3), 3'($urandom_range(0, 7)));
                    1: queue_message($urandom_range(12, 17), 3'($urandom_range(0, 4)));
                    2: queue_message($urandom_range(28, 33), 3'($urandom_range(0, 7)));
                    default: queue_message($urandom_range(0, 40), 3'($urandom_range(0, 4)));
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    wait_drained();
                    hold_sender = 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end

        stim_done = 1'b1;
        repeat (DrainCycles) @(posedge i_clk);
        $display("Run covered %0d message words and %0d digest items over four idling phases.",
                 words_sent, digests_seen);
        if (error_count == 0 && digest_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
